// File: hdl/b64c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared constants and character mapping for the Base64 codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam logic [7:0] PAD_CHAR  = 8'h3D;
  localparam logic       MODE_ENC  = 1'b0;
  localparam logic       MODE_DEC  = 1'b1;
  localparam int         RES_MAX   = 4;
  localparam int         USER_SEND = 0;
  localparam int         USER_ERR  = 1;

  // Map a 6-bit value to its alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      enc_char = w + 8'd65;
    end else if (v < 6'd52) begin
      enc_char = w + 8'd71;
    end else if (v < 6'd62) begin
      enc_char = w - 8'd4;
    end else if (v == 6'd62) begin
      enc_char = 8'h2B;
    end else begin
      enc_char = 8'h2F;
    end
  endfunction

  // Map a character to its 6-bit value; bit 6 set marks an invalid character.
  function automatic logic [6:0] dec_code(input logic [7:0] c);
    logic [7:0] w;
    w = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      w = c - 8'd65;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      w = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      w = c + 8'd4;
    end else if (c == 8'h2B) begin
      w = 8'd62;
    end else if (c == 8'h2F) begin
      w = 8'd63;
    end else begin
      w = 8'd64;
    end
    dec_code = w[6:0];
  endfunction

endpackage

// File: hdl/base64_codec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_codec_unit
// Streaming Base64 encoder/decoder, direction selected by the mode register.
// ----------------------------------------------------------------------------
// Throughput: one input per cycle into the input register, stalled while
// the input's results cannot yet enter the result register; results leave
// one per cycle from a four-entry result register while the output is
// ready. Encoding makes four characters per three bytes.
// Reset: synchronous rst clears mode to encode, the group state and all
// pipeline valids.
module base64_codec_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_data,       // mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_in
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // data_out
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser    // stream_end, error
);

  logic        mode;
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  slot_count, slot_count_next;
  logic [1:0]  pad_count, pad_count_next;

  logic        in_valid;
  logic [7:0]  in_data;
  logic        in_last;

  logic [7:0]  buf_data [b64c_pkg::RES_MAX];
  logic [2:0]  buf_cnt;
  logic        buf_send;
  logic        buf_err;

  logic [7:0]  res_data [b64c_pkg::RES_MAX];
  logic [2:0]  res_cnt;
  logic        res_err;

  logic        out_xfer;
  logic        buf_free;
  logic        advance;

  logic [23:0] grp;
  logic [6:0]  code;
  logic [1:0]  pad_v;
  logic        fail;

  assign cfg_ready     = 1'b1;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign buf_free      = (buf_cnt == 3'd0) || ((buf_cnt == 3'd1) && m_axis_tready);
  assign advance       = in_valid && ((res_cnt == 3'd0) || buf_free);
  assign s_axis_tready = !in_valid || advance;

  assign m_axis_tvalid = (buf_cnt != 3'd0);
  assign m_axis_tdata  = buf_data[0];
  assign m_axis_tlast  = (buf_cnt == 3'd1);
  always_comb begin
    m_axis_tuser = 2'b00;
    m_axis_tuser[b64c_pkg::USER_SEND] = buf_send && (buf_cnt == 3'd1);
    m_axis_tuser[b64c_pkg::USER_ERR]  = buf_err;
  end

  always_comb begin
    grp             = group_bits;
    group_bits_next = group_bits;
    slot_count_next = slot_count;
    pad_count_next  = pad_count;
    res_cnt         = 3'd0;
    res_err         = 1'b0;
    code            = b64c_pkg::dec_code(in_data);
    pad_v           = pad_count;
    fail            = 1'b0;
    for (int k = 0; k < b64c_pkg::RES_MAX; k++) begin
      res_data[k] = 8'd0;
    end
    if (mode == b64c_pkg::MODE_ENC) begin
      case (slot_count)
        2'd0:    grp[23:16] = in_data;
        2'd1:    grp[15:8]  = in_data;
        default: grp[7:0]   = in_data;
      endcase
      if (slot_count == 2'd2 || in_last) begin
        for (int k = 0; k < b64c_pkg::RES_MAX; k++) begin
          if (k <= int'(slot_count) + 1) begin
            res_data[k] = b64c_pkg::enc_char(grp[23 - 6 * k -: 6]);
          end else begin
            res_data[k] = b64c_pkg::PAD_CHAR;
          end
        end
        res_cnt         = 3'd4;
        group_bits_next = 24'd0;
        slot_count_next = 2'd0;
        pad_count_next  = 2'd0;
      end else begin
        group_bits_next = grp;
        slot_count_next = slot_count + 2'd1;
      end
    end else begin
      if (in_data == b64c_pkg::PAD_CHAR) begin
        if (slot_count < 2'd2) begin
          fail = 1'b1;
        end else begin
          pad_v = pad_count + 2'd1;
        end
      end else if (code[6] || pad_count != 2'd0) begin
        fail = 1'b1;
      end else begin
        case (slot_count)
          2'd0:    grp[23:18] = code[5:0];
          2'd1:    grp[17:12] = code[5:0];
          2'd2:    grp[11:6]  = code[5:0];
          default: grp[5:0]   = code[5:0];
        endcase
      end
      if (!fail) begin
        if (slot_count == 2'd3) begin
          res_cnt         = {1'b0, 2'd3 - pad_v};
          res_data[0]     = grp[23:16];
          res_data[1]     = grp[15:8];
          res_data[2]     = grp[7:0];
          group_bits_next = 24'd0;
          slot_count_next = 2'd0;
          pad_count_next  = 2'd0;
        end else if (in_last) begin
          fail = 1'b1;
        end else begin
          group_bits_next = grp;
          slot_count_next = slot_count + 2'd1;
          pad_count_next  = pad_v;
        end
      end
      if (fail) begin
        res_cnt         = 3'd1;
        res_err         = 1'b1;
        res_data[0]     = 8'd0;
        group_bits_next = 24'd0;
        slot_count_next = 2'd0;
        pad_count_next  = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= b64c_pkg::MODE_ENC;
      group_bits <= 24'd0;
      slot_count <= 2'd0;
      pad_count  <= 2'd0;
      in_valid   <= 1'b0;
      buf_cnt    <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode       <= cfg_data[0];
        group_bits <= 24'd0;
        slot_count <= 2'd0;
        pad_count  <= 2'd0;
      end else if (advance) begin
        group_bits <= group_bits_next;
        slot_count <= slot_count_next;
        pad_count  <= pad_count_next;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance && res_cnt != 3'd0) begin
        buf_cnt <= res_cnt;
      end else if (out_xfer) begin
        buf_cnt <= buf_cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
    if (advance && res_cnt != 3'd0) begin
      buf_data <= res_data;
      buf_send <= in_last;
      buf_err  <= res_err;
    end else if (out_xfer) begin
      for (int k = 0; k < b64c_pkg::RES_MAX - 1; k++) begin
        buf_data[k] <= buf_data[k + 1];
      end
    end
  end

endmodule

// File: hdl/b64c_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_checker
// Port-level checks for the Base64 codec, bound to the top level.
// ----------------------------------------------------------------------------
module b64c_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_send_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[b64c_pkg::USER_SEND] |-> m_axis_tlast)
    else $error("stream end on a result that does not close its run");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[b64c_pkg::USER_ERR] |-> m_axis_tlast && m_axis_tdata == 8'd0)
    else $error("error transaction not a single zero result");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind base64_codec_unit b64c_checker u_b64c_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for base64_codec_unit. A short directed table covers
// field extremes and padding both ways; misplaced pads, invalid characters
// and unfinished groups in decode. Random encode and decode streams follow,
// mostly well formed with some corruption. Every accepted input goes through
// an in-bench codec model and each output transaction is compared with the
// oldest predicted character or byte. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [7:0] PAD_CHAR  = b64c_pkg::PAD_CHAR;
  localparam logic       MODE_ENC  = b64c_pkg::MODE_ENC;
  localparam logic       MODE_DEC  = b64c_pkg::MODE_DEC;
  localparam int         USER_SEND = b64c_pkg::USER_SEND;
  localparam int         USER_ERR  = b64c_pkg::USER_ERR;

  localparam int USE_MODEL   = -1;
  localparam int RAND_ITEMS  = 420;
  localparam int SETTLE_CYC  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
    logic       error;
  } codec_res_t;

  typedef struct {
    logic            m;
    logic [7:0]      d;
    logic            l;
    int              tn;
    logic [3:0][7:0] td;
    logic            terr;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_data = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [1:0] m_axis_tuser;

  base64_codec_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  string b64_alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // codec model state
  logic        codec_mode = MODE_ENC;
  logic [23:0] group_acc  = 24'd0;
  logic [1:0]  slots_held = 2'd0;
  logic [1:0]  pads_seen  = 2'd0;

  codec_res_t  step_res [4];
  int          step_cnt;
  codec_res_t  pending_q [$];
  stim_row_t   dir_rows [$];
  int          fail_count = 0;
  bit          calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int six_bits(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  task automatic clear_group();
    group_acc  = 24'd0;
    slots_held = 2'd0;
    pads_seen  = 2'd0;
  endtask

  task automatic add_res(input logic [7:0] d, input logic err);
    step_res[step_cnt] = '{data: d, run_end: err, stream_end: 1'b0, error: err};
    step_cnt++;
  endtask

  task automatic codec_step(input logic [7:0] d, input logic l);
    logic [23:0] sh;
    int          held;
    int          nchr;
    int          nbytes;
    int          code;
    bit          bad;
    step_cnt = 0;
    bad = 1'b0;
    if (codec_mode == MODE_ENC) begin
      group_acc = group_acc | ({16'd0, d} << (16 - 8 * int'(slots_held)));
      held = int'(slots_held) + 1;
      if (held == 3 || l) begin
        nchr = held + 1;
        for (int k = 0; k < 4; k++) begin
          sh = group_acc >> (18 - 6 * k);
          add_res((k < nchr) ? b64_alphabet[sh[5:0]] : PAD_CHAR, 1'b0);
        end
        clear_group();
      end else begin
        slots_held = 2'(held);
      end
    end else begin
      if (d == PAD_CHAR) begin
        if (slots_held < 2'd2) bad = 1'b1;
        else pads_seen = pads_seen + 2'd1;
      end else begin
        code = six_bits(d);
        if (code < 0 || pads_seen != 2'd0) begin
          bad = 1'b1;
        end else begin
          group_acc = group_acc | (24'(code) << (18 - 6 * int'(slots_held)));
        end
      end
      if (!bad && slots_held == 2'd3) begin
        nbytes = 3 - int'(pads_seen);
        for (int k = 0; k < nbytes; k++) begin
          sh = group_acc >> (16 - 8 * k);
          add_res(sh[7:0], 1'b0);
        end
        clear_group();
      end else if (!bad && l) begin
        bad = 1'b1;
      end else if (!bad) begin
        slots_held = slots_held + 2'd1;
      end
      if (bad) begin
        clear_group();
        step_cnt = 0;
        add_res(8'd0, 1'b1);
      end
    end
    if (step_cnt > 0) begin
      step_res[step_cnt-1].run_end    = 1'b1;
      step_res[step_cnt-1].stream_end = l;
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    codec_mode = m;
    clear_group();
  endtask

  task automatic send_item(input stim_row_t r);
    codec_res_t x;
    while (!calm && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.d;
    s_axis_tlast  <= r.l;
    do @(posedge clk); while (!s_axis_tready);
    codec_step(r.d, r.l);
    if (r.tn == USE_MODEL) begin
      for (int k = 0; k < step_cnt; k++) pending_q.push_back(step_res[k]);
    end else begin
      for (int k = 0; k < r.tn; k++) begin
        x.data       = r.terr ? 8'd0 : r.td[k];
        x.run_end    = (k == r.tn - 1);
        x.stream_end = r.l && (k == r.tn - 1);
        x.error      = r.terr;
        pending_q.push_back(x);
      end
    end
  endtask

  task automatic send_rand(input logic [7:0] d, input logic l);
    stim_row_t r;
    r.m = codec_mode;
    r.d = d;
    r.l = l;
    r.tn = USE_MODEL;
    r.td = '0;
    r.terr = 1'b0;
    send_item(r);
  endtask

  task automatic add_row(input logic m, input logic [7:0] d, input logic l, input int tn,
                         input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
                         input logic [7:0] c3, input logic err);
    stim_row_t r;
    r.m = m;
    r.d = d;
    r.l = l;
    r.tn = tn;
    r.td = {c3, c2, c1, c0};
    r.terr = err;
    dir_rows.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    codec_res_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected output transaction data %0h", m_axis_tdata);
        fail_count++;
      end else begin
        w = pending_q.pop_front();
        check_field("data_out", w.data, m_axis_tdata);
        check_field("run_end", 8'(w.run_end), 8'(m_axis_tlast));
        check_field("stream_end", 8'(w.stream_end), 8'(m_axis_tuser[USER_SEND]));
        check_field("error", 8'(w.error), 8'(m_axis_tuser[USER_ERR]));
      end
    end
    m_axis_tready <= rst ? 1'b0 : (calm || $urandom_range(99) >= 16);
  end

  initial begin
    int         sent;
    int         phase;
    int         budget;
    int         len;
    int         ngrp;
    int         npad;
    int         cut;
    int         bad_pos;
    bit         has_last;
    logic       next_mode;
    logic [7:0] b;
    logic [7:0] chars [$];

    // encode rows
    add_row(MODE_ENC, 8'h00, 1'b1, 4, "A", "A", PAD_CHAR, PAD_CHAR, 1'b0);
    add_row(MODE_ENC, 8'hFF, 1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(MODE_ENC, 8'hFF, 1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(MODE_ENC, 8'hFF, 1'b1, 4, "/", "/", "/", "/", 1'b0);
    add_row(MODE_ENC, 8'h4D, 1'b0, USE_MODEL, 0, 0, 0, 0, 1'b0);
    add_row(MODE_ENC, 8'h61, 1'b1, USE_MODEL, 0, 0, 0, 0, 1'b0);
    add_row(MODE_ENC, 8'h00, 1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(MODE_ENC, 8'h00, 1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(MODE_ENC, 8'h00, 1'b0, 4, "A", "A", "A", "A", 1'b0);
    add_row(MODE_ENC, 8'h80, 1'b1, USE_MODEL, 0, 0, 0, 0, 1'b0);
    // decode rows
    add_row(MODE_DEC, PAD_CHAR, 1'b0, 1, 0, 0, 0, 0, 1'b1);
    add_row(MODE_DEC, "A", 1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(MODE_DEC, PAD_CHAR, 1'b0, 1, 0, 0, 0, 0, 1'b1);
    add_row(MODE_DEC, "/", 1'b0, USE_MODEL, 0, 0, 0, 0, 1'b0);
    add_row(MODE_DEC, "/", 1'b0, USE_MODEL, 0, 0, 0, 0, 1'b0);
    add_row(MODE_DEC, "8", 1'b0, USE_MODEL, 0, 0, 0, 0, 1'b0);
    add_row(MODE_DEC, PAD_CHAR, 1'b0, USE_MODEL, 0, 0, 0, 0, 1'b0);
    add_row(MODE_DEC, "Q", 1'b0, USE_MODEL, 0, 0, 0, 0, 1'b0);
    add_row(MODE_DEC, "B", 1'b0, USE_MODEL, 0, 0, 0, 0, 1'b0);
    add_row(MODE_DEC, PAD_CHAR, 1'b0, USE_MODEL, 0, 0, 0, 0, 1'b0);
    add_row(MODE_DEC, "A", 1'b0, 1, 0, 0, 0, 0, 1'b1);
    add_row(MODE_DEC, "*", 1'b0, 1, 0, 0, 0, 0, 1'b1);
    add_row(MODE_DEC, "Q", 1'b1, 1, 0, 0, 0, 0, 1'b1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == 0 || dir_rows[i].m != codec_mode) begin
        wait_idle();
        write_mode(dir_rows[i].m);
      end
      send_item(dir_rows[i]);
    end

    sent = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      next_mode = (phase % 3 == 2) ? codec_mode : ~codec_mode;
      calm = (sent >= 180 && sent < 280);
      wait_idle();
      write_mode(next_mode);
      budget = $urandom_range(60, 30);
      while (budget > 0) begin
        has_last = ($urandom_range(9) != 0);
        chars.delete();
        if (codec_mode == MODE_ENC) begin
          len = $urandom_range(10, 1);
          for (int k = 0; k < len; k++) begin
            b = 8'($urandom_range(255));
            if ($urandom_range(9) == 0) b = $urandom_range(1) ? 8'hFF : 8'h00;
            chars.push_back(b);
          end
        end else begin
          ngrp = $urandom_range(4, 1);
          for (int g = 0; g < ngrp; g++) begin
            npad = 0;
            if (g == ngrp - 1 || $urandom_range(9) == 0) npad = $urandom_range(2);
            for (int s = 0; s < 4; s++) begin
              if (s >= 4 - npad) chars.push_back(PAD_CHAR);
              else chars.push_back(8'(b64_alphabet[$urandom_range(63)]));
            end
          end
          if ($urandom_range(9) == 0) begin
            bad_pos = $urandom_range(chars.size() - 1);
            chars[bad_pos] = 8'($urandom_range(255));
          end
          if ($urandom_range(9) == 0) begin
            cut = $urandom_range(chars.size() - 1, 1);
            while (chars.size() > cut) void'(chars.pop_back());
          end
        end
        for (int k = 0; k < chars.size(); k++) begin
          send_rand(chars[k], has_last && (k == chars.size() - 1));
          sent++;
          budget--;
        end
      end
      phase++;
    end
    calm = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (pending_q.size() != 0) begin
      $error("%0d predicted results never arrived", pending_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/b64c_pkg.sv
hdl/base64_codec_unit.sv
hdl/b64c_checker.sv
tb/tb_top.sv
